FILE: sv/gks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gks_pkg
// shared codes and default sizes for the gaussian kernel smoother
// ----------------------------------------------------------------------------
package gks_pkg;

  localparam int unsigned MAX_SITES_DEF      = 4096;
  localparam int unsigned SIGMA_DEF          = 150000;
  localparam int unsigned DIST_SHIFT_DEF     = 9;
  localparam int unsigned WEIGHT_ENTRIES_DEF = 1024;

  localparam int unsigned POS_W   = 31;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned WGT_W   = 17;
  localparam int unsigned RES_W   = 24;
  localparam int unsigned QBITS   = 24;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_IDX  = 2'd2,
    ST_RESERVED = 2'd3
  } status_t;

endpackage

FILE: sv/gaussian_kernel_smoother.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_kernel_smoother
// stores (position, depth) samples and returns the gaussian weighted mean
// depth around a stored site, in unsigned q16.8
// ----------------------------------------------------------------------------
//
//  channel  | ports                                          | transfer
//  ---------+------------------------------------------------+------------------------
//  input    | in_op, in_sample_position, in_sample_depth,    | start && !busy
//           | in_site_index                                  |
//  result   | out_smoothed_depth, out_status                 | out_valid (one cycle)
//
//  append, clear, unused op codes and a query with a bad site index: result
//  in the cycle after the transfer; query: fetch the site, scan the samples
//  (one sample a cycle through a five stage multiply-accumulate pipe), then
//  restoring division to 24 quotient bits
//  busy is high for the whole query on a stored site; the receiver cannot
//  stall, each result shows for exactly one cycle
//  synchronous active low reset clears the sample count and the sequencer;
//  the sample memory needs no clearing since only written entries are read
//
module gaussian_kernel_smoother
  import gks_pkg::*;
#(
  parameter int unsigned MAX_SITES      = MAX_SITES_DEF,
  parameter int unsigned SIGMA          = SIGMA_DEF,
  parameter int unsigned DIST_SHIFT     = DIST_SHIFT_DEF,
  parameter int unsigned WEIGHT_ENTRIES = WEIGHT_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic [POS_W-1:0]   in_sample_position,
  input  logic [DEPTH_W-1:0] in_sample_depth,
  input  logic [IDX_W-1:0]   in_site_index,
  output logic               out_valid,
  output logic [RES_W-1:0]   out_smoothed_depth,
  output logic [1:0]         out_status
);

  localparam int unsigned AW     = $clog2(MAX_SITES);
  localparam int unsigned CW     = $clog2(MAX_SITES + 1);
  localparam int unsigned RW     = $clog2(WEIGHT_ENTRIES);
  localparam int unsigned SW_W   = WGT_W + CW;
  localparam int unsigned PROD_W = WGT_W + DEPTH_W;
  localparam int unsigned SWD_W  = PROD_W + CW;
  localparam int unsigned DW     = SWD_W + 9;
  localparam int unsigned MEM_W  = POS_W + DEPTH_W;
  localparam longint unsigned SPAN = 3 * longint'(SIGMA);

  // --------------------------------------------------------------------------
  // build-time weight table: e^(-d^2 / (2 sigma^2)) in q1.16
  // --------------------------------------------------------------------------
  function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, b}) begin
        r = r - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] exp_pos(input logic [63:0] f);
    logic [63:0] term;
    logic [63:0] sum;
    term = 64'd1 << 30;
    sum  = 64'd1 << 30;
    for (int i = 1; i <= 20; i++) begin
      term = udiv((term * f) >> 30, 64'(i));
      sum  = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [WGT_W-1:0] weight_at(input int unsigned k);
    logic [63:0] span, den, einv, d, num, n, r, f, w;
    span = 64'(SPAN);
    den  = 64'd2 * 64'(SIGMA) * 64'(SIGMA);
    einv = udiv(64'd1 << 60, exp_pos(64'd1 << 30));
    d    = 64'(k) << DIST_SHIFT;
    if (d > span) begin
      return '0;
    end
    num = d * d;
    n   = udiv(num, den);
    r   = num - n * den;
    f   = '0;
    for (int b = 0; b < 30; b++) begin
      r = r << 1;
      f = f << 1;
      if (r >= den) begin
        r = r - den;
        f = f | 64'd1;
      end
    end
    w = udiv(64'd1 << 60, exp_pos(f));
    for (int q = 0; q < 64; q++) begin
      if (64'(q) < n && w != 0) begin
        w = (w * einv) >> 30;
      end
    end
    w = (w * 64'd65536 + (64'd1 << 29)) >> 30;
    if (w > 64'h1FFFF) begin
      w = 64'h1FFFF;
    end
    return w[WGT_W-1:0];
  endfunction

  logic [WGT_W-1:0] weight_rom [WEIGHT_ENTRIES];

  for (genvar k = 0; k < WEIGHT_ENTRIES; k++) begin : g_rom
    localparam logic [WGT_W-1:0] WVAL = weight_at(k);
    assign weight_rom[k] = WVAL;
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CEN  = 4'b0010,
    S_SCAN = 4'b0100,
    S_DIV  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      j_r, j_nxt;
  logic [POS_W-1:0]   centre_r, centre_nxt;
  logic [4:0]         bit_r, bit_nxt;
  logic               ov_r, ov_nxt;
  logic [RES_W-1:0]   res_r, res_nxt;
  logic [1:0]         stat_r, stat_nxt;

  // accumulation and divider state
  logic [SW_W-1:0]    sum_w_r, sum_w_nxt;
  logic [SWD_W-1:0]   sum_wd_r, sum_wd_nxt;
  logic [DW-1:0]      rem_r, rem_nxt;
  logic [DW-1:0]      dsh_r, dsh_nxt;
  logic [QBITS-1:0]   quo_r, quo_nxt;

  // scan pipe
  logic               v1_r, v2_r, v3_r, v4_r;
  logic [RW-1:0]      ridx_r;
  logic [DEPTH_W-1:0] dep2_r, dep3_r;
  logic [WGT_W-1:0]   w3_r, w4_r;
  logic [PROD_W-1:0]  prod_r;

  // memory
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [MEM_W-1:0]   mem_wdata, mem_rdata;

  logic               accept;
  logic               issue;
  logic               in_win;
  logic [POS_W-1:0]   rd_pos, pos_gap;
  logic [DEPTH_W-1:0] rd_dep;
  logic [POS_W-1:0]   dsh_idx;
  logic [RW-1:0]      ridx_nxt;
  logic [DW-1:0]      num;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign issue  = (state_r == S_SCAN) && (j_r < count_r);

  assign rd_pos = mem_rdata[MEM_W-1 -: POS_W];
  assign rd_dep = mem_rdata[DEPTH_W-1:0];

  // distance and table index for the sample coming out of memory
  always_comb begin
    pos_gap = (rd_pos >= centre_r) ? (rd_pos - centre_r) : (centre_r - rd_pos);
    in_win  = (64'(pos_gap) <= SPAN);
    dsh_idx = pos_gap >> DIST_SHIFT;
    if (64'(dsh_idx) > 64'(WEIGHT_ENTRIES - 1)) begin
      ridx_nxt = RW'(WEIGHT_ENTRIES - 1);
    end else begin
      ridx_nxt = dsh_idx[RW-1:0];
    end
  end

  always_comb begin
    mem_we    = accept && (op_t'(in_op) == OP_APPEND) && (count_r < CW'(MAX_SITES));
    mem_waddr = count_r[AW-1:0];
    mem_wdata = {in_sample_position, in_sample_depth};
    if (state_r == S_IDLE) begin
      mem_raddr = AW'(in_site_index);
    end else begin
      mem_raddr = j_r[AW-1:0];
    end
  end

  gks_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_SITES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign num = (DW'(sum_wd_r) << 8) + DW'(sum_w_r >> 1);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    j_nxt      = j_r;
    centre_nxt = centre_r;
    bit_nxt    = bit_r;
    ov_nxt     = 1'b0;
    res_nxt    = res_r;
    stat_nxt   = stat_r;
    sum_w_nxt  = sum_w_r;
    sum_wd_nxt = sum_wd_r;
    rem_nxt    = rem_r;
    dsh_nxt    = dsh_r;
    quo_nxt    = quo_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt  = '0;
          stat_nxt = ST_OK;
          unique case (op_t'(in_op))
            OP_APPEND: begin
              ov_nxt = 1'b1;
              if (count_r < CW'(MAX_SITES)) begin
                count_nxt = count_r + 1'b1;
              end else begin
                stat_nxt = ST_FULL;
              end
            end
            OP_QUERY: begin
              if (32'(in_site_index) >= 32'(count_r)) begin
                ov_nxt   = 1'b1;
                stat_nxt = ST_BAD_IDX;
              end else begin
                state_nxt = S_CEN;
              end
            end
            OP_CLEAR: begin
              ov_nxt    = 1'b1;
              count_nxt = '0;
            end
            OP_NONE: begin
              ov_nxt = 1'b1;
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end
      S_CEN: begin
        // site position is out of memory now
        centre_nxt = rd_pos;
        j_nxt      = '0;
        sum_w_nxt  = '0;
        sum_wd_nxt = '0;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        if (issue) begin
          j_nxt = j_r + 1'b1;
        end
        if (v4_r) begin
          sum_w_nxt  = sum_w_r + SW_W'(w4_r);
          sum_wd_nxt = sum_wd_r + SWD_W'(prod_r);
        end
        if (!issue && !v1_r && !v2_r && !v3_r && !v4_r) begin
          rem_nxt   = num;
          dsh_nxt   = DW'(sum_w_r) << (QBITS - 1);
          quo_nxt   = '0;
          bit_nxt   = 5'(QBITS - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // restoring division, one quotient bit a cycle
        if (rem_r >= dsh_r) begin
          rem_nxt = rem_r - dsh_r;
          quo_nxt = quo_r | (QBITS'(1) << bit_r);
        end
        dsh_nxt = dsh_r >> 1;
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) begin
          ov_nxt    = 1'b1;
          stat_nxt  = ST_OK;
          res_nxt   = (sum_w_r == '0) ? '0 : quo_nxt;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r && in_win;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    j_r      <= j_nxt;
    centre_r <= centre_nxt;
    bit_r    <= bit_nxt;
    res_r    <= res_nxt;
    stat_r   <= stat_nxt;
    sum_w_r  <= sum_w_nxt;
    sum_wd_r <= sum_wd_nxt;
    rem_r    <= rem_nxt;
    dsh_r    <= dsh_nxt;
    quo_r    <= quo_nxt;
    ridx_r   <= ridx_nxt;
    dep2_r   <= rd_dep;
    w3_r     <= weight_rom[ridx_r];
    dep3_r   <= dep2_r;
    prod_r   <= PROD_W'(dep3_r) * PROD_W'(w3_r);
    w4_r     <= w3_r;
  end

  assign out_valid          = ov_r;
  assign out_smoothed_depth = res_r;
  assign out_status         = stat_r;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_transfer_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted item left without result or work");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SITES))
    else $error("sample count beyond store size");

  a_pipe_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (state_r == S_SCAN))
    else $error("accumulate outside the scan");

endmodule

FILE: sv/gks_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gks_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gks_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
